// ===== rtl/crwt_pkg.sv =====
`timescale 1ns / 1ps

package crwt_pkg;

  // Fixed field widths of the request and reply transfers
  localparam int unsigned ReqW    = 3;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CountW  = 10;
  localparam int unsigned CapW    = 16;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned ReplyW  = 16;

  typedef enum logic [ReqW-1:0] {
    REQ_CREATE   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_CONSUME  = 3'd3,
    REQ_CHECK    = 3'd4,
    REQ_SET_SIZE = 3'd5,
    REQ_SYNC     = 3'd6,
    REQ_READ     = 3'd7
  } req_e;

  // Table update controls from the request logic
  typedef struct packed {
    logic mem_we;
    logic vld_set;
    logic vld_clr;
  } crwt_upd_t;

endpackage

// ===== rtl/crwt_store.sv =====
`timescale 1ns / 1ps

module crwt_store #(
  parameter int unsigned DATA_W = 18,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Forward a write landing on the same edge to the read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/crwt_exec.sv =====
`timescale 1ns / 1ps

module crwt_exec import crwt_pkg::*; #(
  parameter int unsigned WINDOW_BITS = 16
) (
  input  req_e                           req_i,
  input  logic                           in_range_i,
  input  logic                           found_i,
  input  logic        [CountW-1:0]       count_i,
  input  logic signed [CapW-1:0]         cap_i,
  input  logic                           mq_i,
  input  logic signed [ValueW-1:0]       val_i,
  input  logic                           sw_off_i,
  input  logic                           clu_i,
  input  logic signed [WINDOW_BITS-1:0]  old_win_i,
  input  logic                           old_off_i,
  input  logic                           old_clu_i,
  output crwt_upd_t                      upd_o,
  output logic signed [WINDOW_BITS-1:0]  new_win_o,
  output logic                           new_off_o,
  output logic                           new_clu_o,
  output logic signed [ReplyW-1:0]       reply_o,
  output logic                           blocked_o
);

  localparam int unsigned ExtW = ((WINDOW_BITS > ValueW) ? WINDOW_BITS : ValueW) + 2;

  localparam logic signed [ExtW-1:0] WinMax =
      {{(ExtW - WINDOW_BITS + 1){1'b0}}, {(WINDOW_BITS - 1){1'b1}}};
  localparam logic signed [ExtW-1:0] WinMin =
      {{(ExtW - WINDOW_BITS + 1){1'b1}}, {(WINDOW_BITS - 1){1'b0}}};

  function automatic logic signed [WINDOW_BITS-1:0] sat_win(input logic signed [ExtW-1:0] x);
    logic signed [ExtW-1:0] r;
    r = x;
    if (x > WinMax) r = WinMax;
    if (x < WinMin) r = WinMin;
    return r[WINDOW_BITS-1:0];
  endfunction

  function automatic logic signed [ReplyW-1:0] to_reply(input logic signed [WINDOW_BITS-1:0] w);
    logic signed [ExtW-1:0] e;
    e = ExtW'(w);
    return e[ReplyW-1:0];
  endfunction

  logic signed [ExtW-1:0]        win_ext;
  logic signed [ExtW-1:0]        cnt_ext;
  logic signed [ExtW-1:0]        val_ext;
  logic signed [ExtW-1:0]        cap_ext;
  logic signed [WINDOW_BITS-1:0] val_sat;
  logic signed [WINDOW_BITS-1:0] add_sat;
  logic signed [ExtW-1:0]        add_ext;
  logic signed [WINDOW_BITS-1:0] add_win;
  logic signed [WINDOW_BITS-1:0] sub_sat;
  logic                          val_zero;
  logic                          consume_skip;

  assign win_ext  = ExtW'(old_win_i);
  assign cnt_ext  = ExtW'(count_i);
  assign val_ext  = ExtW'(val_i);
  assign cap_ext  = ExtW'(cap_i);
  assign val_zero = (val_i == '0);
  assign val_sat  = sat_win(val_ext);
  assign add_sat  = sat_win(win_ext + cnt_ext);
  assign add_ext  = ExtW'(add_sat);
  // Clamp to the cap only when the cap is nonnegative
  assign add_win  = (!cap_i[CapW-1] && (add_ext > cap_ext)) ? cap_ext[WINDOW_BITS-1:0]
                                                             : add_sat;
  assign sub_sat  = sat_win(win_ext - cnt_ext);
  assign consume_skip = old_off_i || (old_clu_i && mq_i);

  always_comb begin
    upd_o     = '0;
    new_win_o = old_win_i;
    new_off_o = old_off_i;
    new_clu_o = old_clu_i;
    reply_o   = '0;
    blocked_o = 1'b0;
    unique case (req_i)
      REQ_CREATE: begin
        if (in_range_i && !found_i) begin
          new_win_o     = val_zero ? WINDOW_BITS'(1) : val_sat;
          new_off_o     = sw_off_i;
          new_clu_o     = clu_i;
          upd_o.mem_we  = 1'b1;
          upd_o.vld_set = 1'b1;
          reply_o       = to_reply(new_win_o);
        end else if (found_i) begin
          reply_o = to_reply(old_win_i);
        end
      end
      REQ_DELETE: begin
        upd_o.vld_clr = found_i;
      end
      REQ_ADD: begin
        if (found_i) begin
          if (old_off_i) begin
            reply_o = cap_i;
          end else begin
            new_win_o    = add_win;
            upd_o.mem_we = 1'b1;
            reply_o      = to_reply(add_win);
          end
        end
      end
      REQ_CONSUME: begin
        reply_o = ReplyW'(1);
        if (found_i) begin
          if (!consume_skip) begin
            new_win_o    = sub_sat;
            upd_o.mem_we = 1'b1;
          end
          reply_o = to_reply(new_win_o);
        end
      end
      REQ_CHECK: begin
        blocked_o = found_i && old_win_i[WINDOW_BITS-1] && !old_off_i;
      end
      REQ_SET_SIZE: begin
        if (found_i) begin
          new_off_o    = val_zero;
          new_win_o    = val_sat;
          new_clu_o    = clu_i;
          upd_o.mem_we = 1'b1;
          reply_o      = to_reply(val_sat);
        end
      end
      REQ_SYNC: begin
        if (found_i) begin
          new_win_o    = val_sat;
          upd_o.mem_we = 1'b1;
          reply_o      = to_reply(val_sat);
        end
      end
      REQ_READ: begin
        if (found_i) begin
          reply_o = to_reply(old_win_i);
        end
      end
    endcase
  end

endmodule

// ===== rtl/channel_credit_window_table.sv =====
`timescale 1ns / 1ps

// Per-channel credit window table. Every request (create, delete, add, consume,
// check blocked, set size, synchronize, read size) addresses one directly indexed
// entry and returns exactly one reply transfer. The block takes one request per
// clock cycle while the request side is not stalled; the edge of the request
// transfer captures the request into the request stage and reads the entry from
// the window memory, and the edge on which that stage fires computes the update,
// writes it back and loads the reply register. A stalled reply holds the request
// stage, and the request side stalls only while both stages are full. A write
// landing on the same edge as the next read is forwarded, so back-to-back requests
// to one channel see each other's updates. Window arithmetic saturates at the
// signed WINDOW_BITS bounds; replies carry the low 16 bits. Entry valid bits are
// flip-flops cleared by reset, so the table is usable right after reset with no
// clearing pass. Channel numbers at or above CHANNELS read as missing entries.
module channel_credit_window_table import crwt_pkg::*; #(
  parameter int unsigned CHANNELS    = 256,
  parameter int unsigned WINDOW_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic [ChanW-1:0]         channel_i,
  input  logic [CountW-1:0]        count_i,
  input  logic signed [CapW-1:0]   max_window_i,
  input  logic                     caller_is_mq_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     switch_off_i,
  input  logic                     cluster_i,
  // Reply channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ReplyW-1:0] window_o,
  output logic                     blocked_o,
  output logic                     found_o
);

  // Only the first 256 channels are reachable through the 8-bit channel field
  localparam int unsigned Depth  = (CHANNELS < (1 << ChanW)) ? CHANNELS : (1 << ChanW);
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Slots  = 1 << IdxW;
  localparam int unsigned WordW  = WINDOW_BITS + 2;

  // Request stage
  logic                     s1_valid_q, s1_valid_d;
  req_e                     req_q;
  logic [IdxW-1:0]          idx_q;
  logic                     in_range_q;
  logic [CountW-1:0]        count_q;
  logic signed [CapW-1:0]   cap_q;
  logic                     mq_q;
  logic signed [ValueW-1:0] val_q;
  logic                     sw_off_q;
  logic                     clu_q;

  // Reply stage
  logic                     out_valid_q, out_valid_d;
  logic signed [ReplyW-1:0] window_q;
  logic                     blocked_q;
  logic                     found_q;

  // Entry valid bits
  logic [Slots-1:0]         vld_q, vld_d;

  logic                     accept;
  logic                     fire;
  logic [IdxW-1:0]          in_idx;
  logic                     in_range;
  logic                     found;
  logic [WordW-1:0]         rd_word;
  logic [WordW-1:0]         wr_word;
  crwt_upd_t                upd;
  logic signed [WINDOW_BITS-1:0] new_win;
  logic                     new_off;
  logic                     new_clu;
  logic signed [ReplyW-1:0] reply;
  logic                     blocked;

  // Advance the request stage when the reply register is free or draining
  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_idx   = IdxW'(channel_i);
  assign in_range = (32'(channel_i) < CHANNELS);
  assign found    = in_range_q && vld_q[idx_q];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Hold request fields until the stage fires
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_e'(req_type_i);
      idx_q      <= in_idx;
      in_range_q <= in_range;
      count_q    <= count_i;
      cap_q      <= max_window_i;
      mq_q       <= caller_is_mq_i;
      val_q      <= value_i;
      sw_off_q   <= switch_off_i;
      clu_q      <= cluster_i;
    end
  end

  // Window memory: {off flag, cluster flag, window}
  assign wr_word = {new_off, new_clu, new_win};

  crwt_store #(
    .DATA_W (WordW),
    .ADDR_W (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_idx),
    .wr_en_i   (fire && upd.mem_we),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  crwt_exec #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_exec (
    .req_i      (req_q),
    .in_range_i (in_range_q),
    .found_i    (found),
    .count_i    (count_q),
    .cap_i      (cap_q),
    .mq_i       (mq_q),
    .val_i      (val_q),
    .sw_off_i   (sw_off_q),
    .clu_i      (clu_q),
    .old_win_i  (rd_word[WINDOW_BITS-1:0]),
    .old_off_i  (rd_word[WordW-1]),
    .old_clu_i  (rd_word[WordW-2]),
    .upd_o      (upd),
    .new_win_o  (new_win),
    .new_off_o  (new_off),
    .new_clu_o  (new_clu),
    .reply_o    (reply),
    .blocked_o  (blocked)
  );

  // Set on create, drop on delete
  always_comb begin
    vld_d = vld_q;
    if (fire && upd.vld_set) begin
      vld_d[idx_q] = 1'b1;
    end
    if (fire && upd.vld_clr) begin
      vld_d[idx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Reply register: load on fire, empty once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      window_q  <= reply;
      blocked_q <= blocked;
      found_q   <= found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign window_o    = window_q;
  assign blocked_o   = blocked_q;
  assign found_o     = found_q;

  // An empty reply register never stalls the request side
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("request stalled with empty reply register");

  // A fired request always leaves a pending reply
  a_fire_loads_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("fired request produced no reply");

  // Create on an in-range channel leaves the entry valid
  a_create_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q == REQ_CREATE) && in_range_q) |=> vld_q[$past(idx_q)])
    else $error("entry not valid after create");

  // Delete leaves the entry invalid
  a_delete_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q == REQ_DELETE)) |=> !vld_q[$past(idx_q)])
    else $error("entry still valid after delete");

  // Blocked is only ever reported for an existing channel
  a_blocked_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && blocked_q) |-> found_q)
    else $error("blocked reply for missing channel");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the per-channel credit window table. Drive request
// transfers with random gaps, stall reply transfers at random, and compare
// every reply against an in-bench model of the table.
module testbench;
  import crwt_pkg::*;

  localparam int NumChannels = 256;
  localparam int RandomItems = 1850;
  localparam int IdleLimit   = 2000;  // cycles with no transfer on either side
  localparam int DrainCycles = 8;     // allow slack after the last reply
  localparam int PrintLimit  = 40;
  localparam int WinHi       = 32767;
  localparam int WinLo       = -32768;

  typedef struct {
    logic signed [ReplyW-1:0] window;
    logic                     blocked;
    logic                     found;
  } credit_reply_t;

  typedef struct {
    req_e                     req;
    logic [ChanW-1:0]         channel;
    logic [CountW-1:0]        count;
    logic signed [CapW-1:0]   max_window;
    logic                     mq;
    logic signed [ValueW-1:0] value;
    logic                     switch_off;
    logic                     cluster;
    bit                       has_typed;  // row carries a hand-written reply
    credit_reply_t            typed;
  } credit_req_t;

  typedef struct {
    req_e             req;
    logic [ChanW-1:0] channel;
    credit_reply_t    want;
  } reply_due_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ReqW-1:0]          req_type_i;
  logic [ChanW-1:0]         channel_i;
  logic [CountW-1:0]        count_i;
  logic signed [CapW-1:0]   max_window_i;
  logic                     caller_is_mq_i;
  logic signed [ValueW-1:0] value_i;
  logic                     switch_off_i;
  logic                     cluster_i;

  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ReplyW-1:0] window_o;
  logic                     blocked_o;
  logic                     found_o;

  channel_credit_window_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .channel_i      (channel_i),
    .count_i        (count_i),
    .max_window_i   (max_window_i),
    .caller_is_mq_i (caller_is_mq_i),
    .value_i        (value_i),
    .switch_off_i   (switch_off_i),
    .cluster_i      (cluster_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_o       (window_o),
    .blocked_o      (blocked_o),
    .found_o        (found_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the table. Window, off and cluster are only read while the
  // entry is live, so their never-written contents never matter.
  bit                       ch_live    [NumChannels];
  logic signed [ReplyW-1:0] ch_window  [NumChannels];
  bit                       ch_off     [NumChannels];
  bit                       ch_cluster [NumChannels];

  reply_due_t  pending_replies[$];
  credit_req_t directed_rows[$];

  int  mismatch_count = 0;
  int  replies_seen   = 0;
  int  idle_cycles    = 0;
  int  req_seen[8];
  int  live_hits      = 0;
  int  blocked_hits   = 0;
  bit  quiet_phase    = 1'b0;  // no gaps and no stalls while set

  // Saturate to the signed window bounds.
  function automatic logic signed [ReplyW-1:0] clamp_window(int x);
    if (x > WinHi) return ReplyW'(WinHi);
    if (x < WinLo) return ReplyW'(WinLo);
    return ReplyW'(x);
  endfunction

  // Apply one request to the shadow table and return the reply it must produce.
  function automatic credit_reply_t credit_table_step(credit_req_t r);
    credit_reply_t rep;
    int idx;
    int w;
    idx = int'(r.channel);
    rep.window  = '0;
    rep.blocked = 1'b0;
    rep.found   = ch_live[idx];
    case (r.req)
      REQ_CREATE: begin
        // Create on a live channel leaves it alone and echoes its window.
        if (!rep.found) begin
          ch_window[idx]  = (r.value == 0) ? 16'sd1 : r.value;
          ch_off[idx]     = r.switch_off;
          ch_cluster[idx] = r.cluster;
          ch_live[idx]    = 1'b1;
        end
        rep.window = ch_window[idx];
      end
      REQ_DELETE: begin
        ch_live[idx] = 1'b0;
      end
      REQ_ADD: begin
        if (rep.found) begin
          if (ch_off[idx]) begin
            rep.window = r.max_window;
          end else begin
            w = int'(clamp_window(int'(ch_window[idx]) + int'(r.count)));
            if (r.max_window >= 0 && w > int'(r.max_window)) w = int'(r.max_window);
            ch_window[idx] = ReplyW'(w);
            rep.window     = ReplyW'(w);
          end
        end
      end
      REQ_CONSUME: begin
        rep.window = 16'sd1;
        if (rep.found) begin
          // Skip when switched off, or a cluster channel hit from the queue path.
          if (!ch_off[idx] && !(ch_cluster[idx] && r.mq)) begin
            ch_window[idx] = clamp_window(int'(ch_window[idx]) - int'(r.count));
          end
          rep.window = ch_window[idx];
        end
      end
      REQ_CHECK: begin
        if (rep.found) rep.blocked = (ch_window[idx] < 0) && !ch_off[idx];
      end
      REQ_SET_SIZE: begin
        if (rep.found) begin
          ch_off[idx]     = (r.value == 0);
          ch_window[idx]  = r.value;
          ch_cluster[idx] = r.cluster;
          rep.window      = ch_window[idx];
        end
      end
      REQ_SYNC: begin
        if (rep.found) begin
          ch_window[idx] = r.value;
          rep.window     = ch_window[idx];
        end
      end
      default: begin
        if (rep.found) rep.window = ch_window[idx];
      end
    endcase
    return rep;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, rarely a long hold.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, reply_due_t d, int got, int want);
    if (mismatch_count < PrintLimit) begin
      $display("MISMATCH %s: req %s ch %0d got %0d want %0d at %0t",
               what, d.req.name(), d.channel, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  task automatic add_row(req_e t, int ch, int cnt, int cap, bit mq, int val,
                         bit sw, bit cl, bit typed, int w, bit b, bit f);
    credit_req_t r;
    r.req        = t;
    r.channel    = ChanW'(ch);
    r.count      = CountW'(cnt);
    r.max_window = CapW'(cap);
    r.mq         = mq;
    r.value      = ValueW'(val);
    r.switch_off = sw;
    r.cluster    = cl;
    r.has_typed  = typed;
    r.typed.window  = ReplyW'(w);
    r.typed.blocked = b;
    r.typed.found   = f;
    directed_rows.push_back(r);
  endtask

  // Random request aimed at a small set of hot channels, so that entries live
  // long enough to be added to, drained, resized and checked.
  function automatic credit_req_t random_request();
    credit_req_t r;
    int pick;
    r.has_typed     = 1'b0;
    r.typed.window  = '0;
    r.typed.blocked = 1'b0;
    r.typed.found   = 1'b0;

    pick = $urandom_range(0, 99);
    r.channel = (pick < 88) ? ChanW'($urandom_range(0, 11)) : ChanW'($urandom_range(0, 255));

    pick = $urandom_range(0, 99);
    if (pick < 14)      r.req = REQ_CREATE;
    else if (pick < 19) r.req = REQ_DELETE;
    else if (pick < 40) r.req = REQ_ADD;
    else if (pick < 64) r.req = REQ_CONSUME;
    else if (pick < 75) r.req = REQ_CHECK;
    else if (pick < 83) r.req = REQ_SET_SIZE;
    else if (pick < 90) r.req = REQ_SYNC;
    else                r.req = REQ_READ;
    // Steer most requests to a missing channel into a create.
    if (!ch_live[r.channel] && r.req != REQ_CREATE && $urandom_range(0, 99) < 60) begin
      r.req = REQ_CREATE;
    end

    pick = $urandom_range(0, 99);
    if (pick < 45)      r.count = CountW'($urandom_range(0, 31));
    else if (pick < 90) r.count = CountW'($urandom_range(0, 1023));
    else                r.count = $urandom_range(0, 1) ? 10'd1023 : 10'd0;

    pick = $urandom_range(0, 99);
    if (pick < 30)      r.max_window = -16'sd1;
    else if (pick < 65) r.max_window = CapW'($urandom_range(0, 600));
    else                r.max_window = CapW'($urandom_range(0, 32767));

    pick = $urandom_range(0, 99);
    if (pick < 10)      r.value = '0;
    else if (pick < 50) r.value = ValueW'(int'($urandom_range(0, 400)) - 200);
    else                r.value = ValueW'($urandom);

    r.mq         = 1'($urandom_range(0, 1));
    r.cluster    = 1'($urandom_range(0, 1));
    r.switch_off = ($urandom_range(0, 99) < 25);
    return r;
  endfunction

  // Present one request, hold it through stalls, and log the prediction at
  // the edge where the transfer happens.
  task automatic send_request(credit_req_t r);
    int gap;
    reply_due_t due;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i     <= r.req;
    channel_i      <= r.channel;
    count_i        <= r.count;
    max_window_i   <= r.max_window;
    caller_is_mq_i <= r.mq;
    value_i        <= r.value;
    switch_off_i   <= r.switch_off;
    cluster_i      <= r.cluster;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    due.req     = r.req;
    due.channel = r.channel;
    due.want    = credit_table_step(r);
    req_seen[int'(r.req)]++;
    if (due.want.found) live_hits++;
    if (due.want.blocked) blocked_hits++;
    // Hand-written rows must agree with the shadow table too; the typed reply
    // is what gets checked against the block.
    if (r.has_typed) due.want = r.typed;
    pending_replies.push_back(due);
    @(negedge clk_i);
  endtask

  // Reply side: random stall, held for random lengths.
  initial begin : reply_stall
    int len;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      len = pick_gap();
      if (len == 0) begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (len) @(negedge clk_i);
      end
    end
  end

  // Compare each reply transfer with the oldest expectation.
  always @(posedge clk_i) begin : reply_check
    reply_due_t d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        d.req     = REQ_CREATE;
        d.channel = '0;
        report_mismatch("reply with nothing pending", d, int'(window_o), 0);
      end else begin
        d = pending_replies.pop_front();
        if (window_o !== d.want.window) begin
          report_mismatch("window", d, int'(window_o), int'(d.want.window));
        end
        if (blocked_o !== d.want.blocked) begin
          report_mismatch("blocked", d, int'(blocked_o), int'(d.want.blocked));
        end
        if (found_o !== d.want.found) begin
          report_mismatch("found", d, int'(found_o), int'(d.want.found));
        end
      end
    end
  end

  // End the run when neither side has moved a transfer for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("channel_credit_window_table verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_valid_i     = 1'b0;
    req_type_i     = REQ_READ;
    channel_i      = '0;
    count_i        = '0;
    max_window_i   = '0;
    caller_is_mq_i = 1'b0;
    value_i        = '0;
    switch_off_i   = 1'b0;
    cluster_i      = 1'b0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    //       req           ch  cnt   cap  mq  value sw cl  typed  win  blk fnd
    // Empty table after reset: every request sees a missing channel.
    add_row(REQ_READ,       0,    0,    0, 0,      0, 0, 0, 1,      0, 0, 0);
    add_row(REQ_CONSUME,    5,   10,    0, 0,      0, 0, 0, 1,      1, 0, 0);
    add_row(REQ_ADD,        5,   10,  100, 0,      0, 0, 0, 1,      0, 0, 0);
    add_row(REQ_CHECK,      5,    0,    0, 0,      0, 0, 0, 1,      0, 0, 0);
    add_row(REQ_SET_SIZE,   5,    0,    0, 0,     77, 0, 1, 1,      0, 0, 0);
    add_row(REQ_SYNC,       5,    0,    0, 0,     77, 0, 0, 1,      0, 0, 0);
    add_row(REQ_DELETE,     5,    0,    0, 0,      0, 0, 0, 1,      0, 0, 0);
    // Zero window on create is stored as one; a second create is ignored.
    add_row(REQ_CREATE,   255,    0,    0, 0,      0, 1, 0, 1,      1, 0, 0);
    add_row(REQ_CREATE,   255,    0,    0, 0,    100, 0, 1, 1,      1, 0, 1);
    // Switched off: add answers with the cap, here the no-cap value.
    add_row(REQ_ADD,      255, 1023,   -1, 0,      0, 0, 0, 1,     -1, 0, 1);
    add_row(REQ_READ,     255,    0,    0, 0,      0, 0, 0, 1,      1, 0, 1);
    // Cluster channel at the negative bound: blocked, saturates, queue skip.
    add_row(REQ_CREATE,     0,    0,    0, 0, -32768, 0, 1, 1, -32768, 0, 0);
    add_row(REQ_CHECK,      0,    0,    0, 0,      0, 0, 0, 1,      0, 1, 1);
    add_row(REQ_CONSUME,    0, 1023,    0, 0,      0, 0, 0, 1, -32768, 0, 1);
    add_row(REQ_CONSUME,    0,    5,    0, 1,      0, 0, 0, 1, -32768, 0, 1);
    add_row(REQ_ADD,        0, 1023,   -1, 0,      0, 0, 0, 0,      0, 0, 0);
    // Positive bound, then the cap clamp.
    add_row(REQ_SET_SIZE,   0,    0,    0, 0,  32767, 0, 0, 1,  32767, 0, 1);
    add_row(REQ_ADD,        0, 1023,   -1, 0,      0, 0, 0, 1,  32767, 0, 1);
    add_row(REQ_ADD,        0,   10,  100, 0,      0, 0, 0, 1,    100, 0, 1);
    add_row(REQ_ADD,        0,    0, 32767, 0,     0, 0, 0, 0,      0, 0, 0);
    // Set size zero switches the channel off: add returns the cap, consume
    // is skipped, and a negative window no longer blocks.
    add_row(REQ_SET_SIZE,   0,    0,    0, 0,      0, 0, 0, 1,      0, 0, 1);
    add_row(REQ_ADD,        0,    7, 1234, 0,      0, 0, 0, 1,   1234, 0, 1);
    add_row(REQ_CONSUME,    0,   50,    0, 0,      0, 0, 0, 1,      0, 0, 1);
    add_row(REQ_SYNC,       0,    0,    0, 0,     -5, 0, 0, 1,     -5, 0, 1);
    add_row(REQ_CHECK,      0,    0,    0, 0,      0, 0, 0, 1,      0, 0, 1);
    add_row(REQ_DELETE,     0,    0,    0, 0,      0, 0, 0, 1,      0, 0, 1);
    add_row(REQ_READ,       0,    0,    0, 0,      0, 0, 0, 1,      0, 0, 0);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Every fourth stretch of 150 requests runs with no gaps and no stalls.
    for (int i = 0; i < RandomItems; i++) begin
      quiet_phase = ((i / 150) % 4 == 3);
      send_request(random_request());
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d create, %0d delete, %0d add, %0d consume, %0d check requests;",
             req_seen[REQ_CREATE], req_seen[REQ_DELETE], req_seen[REQ_ADD],
             req_seen[REQ_CONSUME], req_seen[REQ_CHECK]);
    $display("%0d set size, %0d sync, %0d read; %0d on live channels, %0d blocked, %0d replies.",
             req_seen[REQ_SET_SIZE], req_seen[REQ_SYNC], req_seen[REQ_READ],
             live_hits, blocked_hits, replies_seen);
    if (mismatch_count == 0) begin
      $display("channel_credit_window_table verification clean");
    end else begin
      $display("channel_credit_window_table verification failed");
    end
    $finish;
  end

endmodule
